// ===== hw/rtl/fnv1a_mesh_fingerprint_defines.svh =====
// ----------------------------------------------------------------------------
// fnv1a_mesh_fingerprint_defines.svh
// Assertion macros for the mesh fingerprint checker.
// ----------------------------------------------------------------------------
`ifndef FNV1A_MESH_FINGERPRINT_DEFINES_SVH
`define FNV1A_MESH_FINGERPRINT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FMF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("fmf assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define FMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("fmf assertion failed");

`endif

// ===== hw/rtl/fmf_pkg.sv =====
// ----------------------------------------------------------------------------
// fmf_pkg
// Constants and types for the FNV-1a mesh fingerprint block.
// ----------------------------------------------------------------------------
package fmf_pkg;

    localparam logic [63:0] HASH_BASIS    = 64'hCBF2_9CE4_8422_2325;
    // prime = 2^40 + 0x1B3
    localparam int          PRIME_SHIFT   = 40;
    localparam logic [8:0]  PRIME_LOW     = 9'h1B3;
    localparam logic [63:0] NEG_ZERO_BITS = 64'h8000_0000_0000_0000;

    localparam logic [1:0]  KIND_COUNT    = 2'd0;
    localparam logic [1:0]  KIND_COORD    = 2'd1;
    localparam logic [1:0]  KIND_INDEX    = 2'd2;

    localparam logic [2:0]  LAST_BYTE_IDX = 3'd3;
    localparam logic [2:0]  LAST_BYTE_ALL = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HASH = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

// ===== hw/rtl/fnv1a_mesh_fingerprint.sv =====
// Steps: an index word takes 4 byte steps, any other word 8, one per cycle,
// paced by the single xor/shift-add multiply unit; a word marked last then
// goes through ST_EMIT to load the output register.
// Input: in_stall holds off a new word until the previous word is hashed;
// a last word also holds it in ST_EMIT while the previous fingerprint stalls.
// Reset: rst_n clears control and out_valid, hash set to the offset basis.
// ----------------------------------------------------------------------------
// fnv1a_mesh_fingerprint
// Folds tagged 64-bit words into a 64-bit FNV-1a hash, one byte per cycle.
// ----------------------------------------------------------------------------
module fnv1a_mesh_fingerprint
    import fmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [1:0]  word_kind,
    input  logic        end_of_mesh,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] fingerprint
);

    state_t      state_reg, state_next;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] word_reg, word_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  last_reg, last_next;
    logic        eom_reg, eom_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] fp_reg, fp_next;

    logic        in_xfer;
    logic        out_xfer;
    logic [63:0] mix_in;
    logic [63:0] mix_out;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign fingerprint = fp_reg;
    assign out_xfer    = out_valid_reg && !out_stall;

    // shared byte step: (h ^ b) * prime
    assign mix_in  = hash_reg ^ {56'd0, word_reg[7:0]};
    assign mix_out = (mix_in << PRIME_SHIFT) + (mix_in * {55'd0, PRIME_LOW});

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        eom_next       = eom_reg;
        fp_next        = fp_reg;
        out_valid_next = out_valid_reg;

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cnt_next  = 3'd0;
                    eom_next  = end_of_mesh;
                    last_next = (word_kind == KIND_INDEX) ? LAST_BYTE_IDX : LAST_BYTE_ALL;
                    if (word_kind == KIND_COORD && data_word == NEG_ZERO_BITS)
                    begin
                        word_next = 64'd0;
                    end
                    else
                    begin
                        word_next = data_word;
                    end
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                hash_next = mix_out;
                word_next = {8'd0, word_reg[63:8]};
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == last_reg)
                begin
                    state_next = eom_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fp_next        = hash_reg;
                    out_valid_next = 1'b1;
                    hash_next      = HASH_BASIS;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= HASH_BASIS;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 3'd0;
            last_reg      <= LAST_BYTE_ALL;
            eom_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            eom_reg       <= eom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        fp_reg   <= fp_next;
    end

endmodule

// ===== hw/rtl/fmf_checker.sv =====
// ----------------------------------------------------------------------------
// fmf_checker
// Port-level checks on the mesh fingerprint block, bound to the top level.
// ----------------------------------------------------------------------------
`include "fnv1a_mesh_fingerprint_defines.svh"

module fmf_checker
    import fmf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  word_kind,
    input logic        end_of_mesh,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] fingerprint
);

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    `FMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(fingerprint))
    `FMF_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall)
    `FMF_ASSERT_SAME(a_index_pace, in_xfer && !end_of_mesh && word_kind == KIND_INDEX, ##5 !in_stall)
    `FMF_ASSERT_SAME(a_full_pace, in_xfer && !end_of_mesh && word_kind != KIND_INDEX, ##9 !in_stall)

endmodule

bind fnv1a_mesh_fingerprint fmf_checker u_fmf_checker (.*);
